@@ sv/sled_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg
// Types, character codes and helper functions shared by the string literal
// escape decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int LEN_BITS = 16;
  localparam int LIT_W    = 16;
  localparam int WIDE_W   = (LEN_BITS > LIT_W) ? LEN_BITS : LIT_W;

  localparam logic [LEN_BITS-1:0] CNT_MAX = {LEN_BITS{1'b1}};
  localparam logic [LIT_W-1:0]    LIT_MAX = {LIT_W{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX1,
    MODE_HEX2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_DONE,
    KIND_ERR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_UNKNOWN_ESC,
    ERR_BAD_HEX,
    ERR_UNTERM
  } err_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    err_t             err;
    logic [LIT_W-1:0] len;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = b[3:0];
    if (b inside {[8'h30:8'h39]}) begin
      h.val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.val = 4'(b[3:0] + 4'd9);
    end else begin
      h.ok  = 1'b0;
      h.val = 4'd0;
    end
    return h;
  endfunction

  // count clipped to the reported field width
  function automatic logic [LIT_W-1:0] len_report(input logic [LEN_BITS-1:0] c);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(c);
    if (wide > WIDE_W'(LIT_MAX)) begin
      return LIT_MAX;
    end else begin
      return wide[LIT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/sled_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sled_if
// Valid/ready channels of the escape decoder: source bytes in, results out.
// ----------------------------------------------------------------------------
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

interface sled_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  err_code;
  logic [15:0] lit_length;

  modport source (output valid, output kind, output out_byte, output err_code,
                  output lit_length, input ready);
  modport sink   (input valid, input kind, input out_byte, input err_code,
                  input lit_length, output ready);
endinterface
`default_nettype wire

@@ sv/sled_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sled_decode
// Literal/escape state machine: one source byte per step, at most one result.
// ----------------------------------------------------------------------------
module sled_decode (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire logic [7:0]              src_byte,
  output      logic                    res_vld,
  output      sled_pkg::res_t          res
);

  sled_pkg::mode_t                  mode_r, mode_nxt;
  logic [3:0]                       nib_r, nib_nxt;
  logic [sled_pkg::LEN_BITS-1:0]    cnt_r, cnt_nxt;
  logic [sled_pkg::LEN_BITS-1:0]    cnt_inc;
  sled_pkg::hex_t                   hd;

  assign hd      = sled_pkg::hex_digit(src_byte);
  assign cnt_inc = (cnt_r == sled_pkg::CNT_MAX) ? cnt_r
                                                : cnt_r + sled_pkg::LEN_BITS'(1);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    nib_nxt  = nib_r;
    cnt_nxt  = cnt_r;
    case (mode_r)
      sled_pkg::MODE_IDLE: begin
        if (src_byte == sled_pkg::CH_QUOTE) begin
          mode_nxt = sled_pkg::MODE_BODY;
          cnt_nxt  = '0;
          nib_nxt  = '0;
        end
      end
      sled_pkg::MODE_BODY: begin
        if (src_byte == sled_pkg::CH_NUL) begin
          mode_nxt = sled_pkg::MODE_IDLE;
          nib_nxt  = '0;
        end else if (src_byte == sled_pkg::CH_QUOTE) begin
          mode_nxt = sled_pkg::MODE_IDLE;
        end else if (src_byte == sled_pkg::CH_BSLASH) begin
          mode_nxt = sled_pkg::MODE_ESC;
        end else begin
          cnt_nxt  = cnt_inc;
        end
      end
      sled_pkg::MODE_ESC: begin
        if (src_byte inside {sled_pkg::CH_N, sled_pkg::CH_R, sled_pkg::CH_T,
                             sled_pkg::CH_QUOTE, sled_pkg::CH_BSLASH}) begin
          mode_nxt = sled_pkg::MODE_BODY;
          cnt_nxt  = cnt_inc;
        end else if (src_byte == sled_pkg::CH_X) begin
          mode_nxt = sled_pkg::MODE_HEX1;
        end else begin
          mode_nxt = sled_pkg::MODE_IDLE;
          nib_nxt  = '0;
        end
      end
      sled_pkg::MODE_HEX1: begin
        if (hd.ok) begin
          mode_nxt = sled_pkg::MODE_HEX2;
          nib_nxt  = hd.val;
        end else begin
          mode_nxt = sled_pkg::MODE_IDLE;
          nib_nxt  = '0;
        end
      end
      sled_pkg::MODE_HEX2: begin
        if (hd.ok) begin
          mode_nxt = sled_pkg::MODE_BODY;
          cnt_nxt  = cnt_inc;
        end else begin
          mode_nxt = sled_pkg::MODE_IDLE;
          nib_nxt  = '0;
        end
      end
      default: begin
        mode_nxt = sled_pkg::MODE_IDLE;
      end
    endcase
  end

  // result
  always_comb begin
    res_vld   = 1'b0;
    res.kind  = sled_pkg::KIND_BYTE;
    res.data  = '0;
    res.err   = sled_pkg::ERR_NONE;
    res.len   = '0;
    case (mode_r)
      sled_pkg::MODE_BODY: begin
        if (src_byte == sled_pkg::CH_NUL) begin
          res_vld  = 1'b1;
          res.kind = sled_pkg::KIND_ERR;
          res.err  = sled_pkg::ERR_UNTERM;
        end else if (src_byte == sled_pkg::CH_QUOTE) begin
          res_vld  = 1'b1;
          res.kind = sled_pkg::KIND_DONE;
          res.len  = sled_pkg::len_report(cnt_r);
        end else if (src_byte != sled_pkg::CH_BSLASH) begin
          res_vld  = 1'b1;
          res.data = src_byte;
        end
      end
      sled_pkg::MODE_ESC: begin
        res_vld = (src_byte != sled_pkg::CH_X);
        case (src_byte)
          sled_pkg::CH_N:      res.data = sled_pkg::CH_LF;
          sled_pkg::CH_R:      res.data = sled_pkg::CH_CR;
          sled_pkg::CH_T:      res.data = sled_pkg::CH_TAB;
          sled_pkg::CH_QUOTE,
          sled_pkg::CH_BSLASH: res.data = src_byte;
          sled_pkg::CH_X:      res.data = '0;
          sled_pkg::CH_NUL: begin
            res.kind = sled_pkg::KIND_ERR;
            res.err  = sled_pkg::ERR_UNTERM;
          end
          default: begin
            res.kind = sled_pkg::KIND_ERR;
            res.err  = sled_pkg::ERR_UNKNOWN_ESC;
          end
        endcase
      end
      sled_pkg::MODE_HEX1: begin
        if (!hd.ok) begin
          res_vld  = 1'b1;
          res.kind = sled_pkg::KIND_ERR;
          res.err  = sled_pkg::ERR_BAD_HEX;
        end
      end
      sled_pkg::MODE_HEX2: begin
        res_vld = 1'b1;
        if (hd.ok) begin
          res.data = {nib_r, hd.val};
        end else begin
          res.kind = sled_pkg::KIND_ERR;
          res.err  = sled_pkg::ERR_BAD_HEX;
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
    res_vld = res_vld & step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sled_pkg::MODE_IDLE;
      nib_r  <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/string_literal_escape_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes double-quoted string literals with escapes from a byte stream.
//
// One source byte is taken per cycle, sustained, while the result side keeps
// up. Each byte is captured in an input register, decoded by one step of the
// literal state machine and lands in a result register. A byte yields zero
// or one result word (decoded byte, literal complete with saturated length,
// or error). A byte of 0 marks end of input. A stalled result register
// holds the input register, so the input side backs up once the input
// register holds a word.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder (
  input wire logic  clk,
  input wire logic  rst_n,
  sled_in_if.sink   in_if,
  sled_out_if.source out_if
);

  logic           in_vld_r;
  logic [7:0]     in_byte_r;
  logic           out_vld_r;
  sled_pkg::res_t res_r;
  logic           adv;
  logic           step;
  logic           res_vld;
  sled_pkg::res_t res;

  assign adv         = !out_vld_r || out_if.ready;
  assign step        = in_vld_r && adv;
  assign in_if.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.src_byte;
    end
  end

  sled_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .src_byte (in_byte_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.kind       = res_r.kind;
  assign out_if.out_byte   = res_r.data;
  assign out_if.err_code   = res_r.err;
  assign out_if.lit_length = res_r.len;

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |=> in_vld_r && $stable(in_byte_r))
    else $error("input stage lost a pending word");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.kind == sled_pkg::KIND_ERR |-> res_r.err != sled_pkg::ERR_NONE)
    else $error("error word without error code");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.kind == sled_pkg::KIND_BYTE
      |-> res_r.err == sled_pkg::ERR_NONE && res_r.len == '0)
    else $error("byte word carries error or length");

  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r && adv |=> !out_vld_r)
    else $error("result word without an input word");
`endif

endmodule
`default_nettype wire
